/* src/three_lane_priority_queue_cancel_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three-lane priority queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_LANE_PRIORITY_QUEUE_CANCEL_TOP_MACROS_SVH
`define THREE_LANE_PRIORITY_QUEUE_CANCEL_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TLPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by an outcome in the next cycle.
`define TLPQ_ASSERT_NEXT(name, cond, nxt, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

/* src/tlpq_pkg.sv */
// ----------------------------------------------------------------------------
// tlpq_pkg
// Sizes, codes, entry layout and address helpers for the priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpq_pkg;

    localparam int LANE_DEPTH  = 16;
    localparam int TAG_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int NUM_LANES   = 3;
    localparam int CNT_W       = $clog2(LANE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(NUM_LANES * LANE_DEPTH);
    localparam int ENTRY_W     = TAG_BITS + TIME_BITS;
    localparam int STORE_DEPTH = NUM_LANES * LANE_DEPTH;
    localparam int COUNT_OUT_W = 5;

    typedef logic [1:0] lane_t;

    localparam lane_t LANE_CTRL = 2'd0;
    localparam lane_t LANE_TOOL = 2'd1;
    localparam lane_t LANE_ANY  = 2'd2;
    localparam lane_t LANE_NONE = 2'd3;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CANCEL,
        OP_PEEK
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_MISS
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] ctime;
    } entry_t;

    function automatic logic [ADDR_W-1:0] entry_addr(lane_t lane, cnt_t idx);
        logic [31:0] a;
        a = 32'(lane) * 32'(LANE_DEPTH) + 32'(idx);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] to_count_out(cnt_t c);
        logic [31:0] w;
        w = 32'(c);
        return w[COUNT_OUT_W-1:0];
    endfunction

endpackage

/* src/tlpq_ram.sv */
// ----------------------------------------------------------------------------
// tlpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/three_lane_priority_queue_cancel_top.sv */
// ----------------------------------------------------------------------------
// three_lane_priority_queue_cancel_top
// Three FIFO lanes (control, tool continuation, any request) of tag and
// creation time, served in strict priority, with cancel by tag.
//
// Command channel: a command transfers on a rising edge with start high and
// busy low. Result channel: done is high for one cycle with status, lane,
// tag, time and the three lane counts; the receiver cannot stall it.
// Push, and pop or peek on an empty queue, answer with busy kept low. Peek
// reads the head of the highest-priority nonempty lane and leaves it; pop
// also shifts the later entries of that lane down one place. Cancel scans
// the lanes in priority order for the tag; a hit drops the entry and closes
// the gap behind it, a miss answers with ST_MISS. Otherwise busy stays high
// until done. All entries live in one RAM of 3 * LANE_DEPTH words with one
// read and one write port. Reset empties all lanes at once and needs no
// clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_lane_priority_queue_cancel_top_macros.svh"

module three_lane_priority_queue_cancel_top
    import tlpq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             opcode,
    input  logic [1:0]             priority_req,
    input  logic [TAG_BITS-1:0]    job_tag,
    input  logic [TIME_BITS-1:0]   created_time,
    output logic                   done,
    output logic [1:0]             status,
    output logic [1:0]             lane_of_result,
    output logic [TAG_BITS-1:0]    result_tag,
    output logic [TIME_BITS-1:0]   result_time,
    output logic [COUNT_OUT_W-1:0] count_control,
    output logic [COUNT_OUT_W-1:0] count_tool,
    output logic [COUNT_OUT_W-1:0] count_any
);

    state_t                         state_reg, state_next;
    op_t                            op_reg, op_next;
    logic [TAG_BITS-1:0]            key_reg, key_next;
    lane_t                          lane_reg, lane_next;
    logic [NUM_LANES-1:0][CNT_W-1:0] fill_reg, fill_next;
    lane_t                          scan_lane_reg, scan_lane_next;
    cnt_t                           scan_idx_reg, scan_idx_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    lane_t                          cmp_lane_reg, cmp_lane_next;
    cnt_t                           cmp_idx_reg, cmp_idx_next;
    cnt_t                           rd_idx_reg, rd_idx_next;
    cnt_t                           wr_idx_reg, wr_idx_next;
    logic                           wr_vld_reg, wr_vld_next;
    logic                           done_reg, done_next;
    status_t                        status_reg, status_next;
    lane_t                          out_lane_reg, out_lane_next;
    logic [TAG_BITS-1:0]            out_tag_reg, out_tag_next;
    logic [TIME_BITS-1:0]           out_time_reg, out_time_next;

    logic                accept;
    lane_t               push_lane;
    lane_t               head_lane;
    cnt_t                sel_fill;
    entry_t              rd_entry;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    function automatic cnt_t pick_fill(logic [NUM_LANES-1:0][CNT_W-1:0] f, lane_t l);
        cnt_t r;
        case (l)
            LANE_CTRL: r = f[0];
            LANE_TOOL: r = f[1];
            LANE_ANY:  r = f[2];
            default:   r = '0;
        endcase
        return r;
    endfunction

    tlpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;

    assign push_lane = (priority_req > LANE_ANY) ? LANE_ANY : priority_req;
    assign head_lane = (fill_reg[0] != '0) ? LANE_CTRL :
                       (fill_reg[1] != '0) ? LANE_TOOL : LANE_ANY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_vld_reg  <= wr_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        lane_reg      <= lane_next;
        scan_lane_reg <= scan_lane_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_lane_reg  <= cmp_lane_next;
        cmp_idx_reg   <= cmp_idx_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        status_reg    <= status_next;
        out_lane_reg  <= out_lane_next;
        out_tag_reg   <= out_tag_next;
        out_time_reg  <= out_time_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        lane_next      = lane_reg;
        fill_next      = fill_reg;
        scan_lane_next = scan_lane_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_lane_next  = cmp_lane_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wr_vld_next    = wr_vld_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_lane_next  = out_lane_reg;
        out_tag_next   = out_tag_reg;
        out_time_next  = out_time_reg;
        sel_fill       = '0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(opcode);
                    key_next = job_tag;
                    if (op_t'(opcode) == OP_PUSH)
                    begin
                        sel_fill      = pick_fill(fill_reg, push_lane);
                        done_next     = 1'b1;
                        out_lane_next = LANE_CTRL;
                        out_tag_next  = '0;
                        out_time_next = '0;
                        if (sel_fill >= CNT_W'(LANE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = entry_addr(push_lane, sel_fill);
                            ram_wdata            = {job_tag, created_time};
                            fill_next[push_lane] = sel_fill + 1'b1;
                            status_next          = ST_OK;
                        end
                    end
                    else if (op_t'(opcode) inside {OP_POP, OP_PEEK})
                    begin
                        if (fill_reg == '0)
                        begin
                            done_next     = 1'b1;
                            status_next   = ST_EMPTY;
                            out_lane_next = LANE_CTRL;
                            out_tag_next  = '0;
                            out_time_next = '0;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = entry_addr(head_lane, '0);
                            lane_next  = head_lane;
                            state_next = S_HEAD;
                        end
                    end
                    else
                    begin
                        scan_lane_next = LANE_CTRL;
                        scan_idx_next  = '0;
                        cmp_vld_next   = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_HEAD:
            begin
                out_lane_next = lane_reg;
                out_tag_next  = rd_entry.tag;
                out_time_next = rd_entry.ctime;
                if (op_reg == OP_PEEK)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_idx_next = CNT_W'(1);
                    wr_vld_next = 1'b0;
                    state_next  = S_SHIFT;
                end
            end

            S_SCAN:
            begin
                sel_fill = pick_fill(fill_reg, scan_lane_reg);
                if (cmp_vld_reg && rd_entry.tag == key_reg)
                begin
                    // hit: drop the entry and close the gap behind it
                    out_lane_next = cmp_lane_reg;
                    out_tag_next  = rd_entry.tag;
                    out_time_next = rd_entry.ctime;
                    lane_next     = cmp_lane_reg;
                    rd_idx_next   = cmp_idx_reg + 1'b1;
                    wr_vld_next   = 1'b0;
                    cmp_vld_next  = 1'b0;
                    state_next    = S_SHIFT;
                end
                else if (scan_lane_reg != LANE_NONE)
                begin
                    if (scan_idx_reg < sel_fill)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = entry_addr(scan_lane_reg, scan_idx_reg);
                        cmp_vld_next  = 1'b1;
                        cmp_lane_next = scan_lane_reg;
                        cmp_idx_next  = scan_idx_reg;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                    else
                    begin
                        cmp_vld_next   = 1'b0;
                        scan_lane_next = scan_lane_reg + 1'b1;
                        scan_idx_next  = '0;
                    end
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_MISS;
                        out_lane_next = LANE_CTRL;
                        out_tag_next  = '0;
                        out_time_next = '0;
                        state_next    = S_IDLE;
                    end
                end
            end

            S_SHIFT:
            begin
                sel_fill = pick_fill(fill_reg, lane_reg);
                if (wr_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = entry_addr(lane_reg, wr_idx_reg);
                    ram_wdata = ram_rdata;
                end
                if (rd_idx_reg < sel_fill)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = entry_addr(lane_reg, rd_idx_reg);
                    wr_idx_next = rd_idx_reg - 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    wr_vld_next = 1'b1;
                end
                else
                begin
                    fill_next[lane_reg] = sel_fill - 1'b1;
                    wr_vld_next         = 1'b0;
                    done_next           = 1'b1;
                    status_next         = ST_OK;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign lane_of_result = out_lane_reg;
    assign result_tag     = out_tag_reg;
    assign result_time    = out_time_reg;
    assign count_control  = to_count_out(fill_reg[0]);
    assign count_tool     = to_count_out(fill_reg[1]);
    assign count_any      = to_count_out(fill_reg[2]);

    `TLPQ_ASSERT(a_fill_bound, fill_reg[0] <= CNT_W'(LANE_DEPTH) && fill_reg[1] <= CNT_W'(LANE_DEPTH) && fill_reg[2] <= CNT_W'(LANE_DEPTH), "lane fill above depth")
    `TLPQ_ASSERT(a_no_write_in_read, (state_reg == S_HEAD || state_reg == S_SCAN) |-> !ram_we, "store written during head read or scan")
    `TLPQ_ASSERT(a_shift_no_overlap, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "shift reads and writes the same entry")
    `TLPQ_ASSERT_NEXT(a_accept_progress, accept, done || busy, "accepted command neither done nor busy")

endmodule
